FILE: rtl/core/sti_pkg.sv
// Shared constants for the sphere/triangle intersection block.
// Used by sti_mul and sphere_triangle_intersect; depends on nothing.
`default_nettype none

package sti_pkg;

    // Default coordinate width (signed, 10 fraction bits)
    localparam int COORD_WIDTH_DEF = 21;
    // Radius width (unsigned, 10 fraction bits)
    localparam int RADIUS_WIDTH = 20;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX_A = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX_B = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX_C = 2'd2;

    // Wide multiplier: limb size of one partial product and its latency
    localparam int MUL_LIMB = 24;
    localparam int MUL_LATENCY = 4;

    // Cycles the triangle setup pipeline needs after a register write
    localparam int SETTLE_CYCLES = 12;

endpackage

`default_nettype wire

FILE: rtl/core/sti_mul.sv
// Pipelined signed multiplier built from limb partial products (4 stages).
// Depends on sti_pkg for the limb size.
`default_nettype none

module sti_mul #(
    parameter int AW = 8,
    parameter int BW = 8
) (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [AW-1:0]    a,
    input  wire logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0]      p
);

    localparam int LIMB = sti_pkg::MUL_LIMB;
    localparam int NA   = (AW + LIMB - 1) / LIMB;
    localparam int NB   = (BW + LIMB - 1) / LIMB;
    localparam int PW   = AW + BW;

    logic [AW-1:0]          mag_a_reg;
    logic [BW-1:0]          mag_b_reg;
    logic                   neg1_reg;
    logic                   neg2_reg;
    logic                   neg3_reg;
    logic [NA*LIMB-1:0]     a_pad;
    logic [NB*LIMB-1:0]     b_pad;
    logic [2*LIMB-1:0]      pp_reg [NA][NB];
    logic [PW-1:0]          row_next [NA];
    logic [PW-1:0]          row_reg [NA];
    logic [PW-1:0]          sum_next;
    logic [PW-1:0]          p_next;
    logic signed [PW-1:0]   p_reg;

    // Stage 1: take magnitudes, keep the product sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_a_reg <= a[AW-1] ? AW'(-a) : AW'(a);
            mag_b_reg <= b[BW-1] ? BW'(-b) : BW'(b);
            neg1_reg  <= a[AW-1] ^ b[BW-1];
        end
    end

    assign a_pad = (NA*LIMB)'(mag_a_reg);
    assign b_pad = (NB*LIMB)'(mag_b_reg);

    // Stage 2: limb partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= a_pad[i*LIMB +: LIMB] * b_pad[j*LIMB +: LIMB];
                end
            end
            neg2_reg <= neg1_reg;
        end
    end

    // Stage 3: sum each row of partial products
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (PW'(pp_reg[i][j]) << (j*LIMB));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                row_reg[i] <= row_next[i];
            end
            neg3_reg <= neg2_reg;
        end
    end

    // Stage 4: sum the rows and restore the sign
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            sum_next = sum_next + (row_reg[i] << (i*LIMB));
        end
        p_next = neg3_reg ? (~sum_next + PW'(1)) : sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sphere_triangle_intersect.sv
// Sphere against triangle hit test, top level.
// Depends on sti_pkg and sti_mul.
//
// Usage:
//   Write the triangle through the configuration channel (cfg_valid/cfg_ready,
//   cfg_index 0..2 selects vertex a, b or c; other indexes are ignored).
//   cfg_ready is always high. Each write restarts the setup settle counter;
//   the input channel stalls during the write cycle and until it runs out.
//   Out of reset the same settle count runs before the first sphere is taken.
//   Spheres enter on in_valid/in_stall; one per cycle while in_stall is low.
//   Each sphere gives one transaction on out_valid/out_stall carrying hit.
//   A sphere passes from acceptance to out_valid through three stages of
//   differences and narrow products, two 4-stage wide multipliers in series
//   (cross-product squares, then the face distance square) and their sum and
//   compare stages. Throughput is one sphere per cycle unless a stall holds it.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears the vertices to zero and empties the pipeline.
`default_nettype none

module sphere_triangle_intersect #(
    parameter int COORD_WIDTH = sti_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // sphere input
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [COORD_WIDTH-1:0]          center_x,
    input  wire logic signed [COORD_WIDTH-1:0]          center_y,
    input  wire logic signed [COORD_WIDTH-1:0]          center_z,
    input  wire logic [sti_pkg::RADIUS_WIDTH-1:0]       sphere_radius,
    // result output
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        hit,
    // configuration writes
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [sti_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [3*COORD_WIDTH-1:0]               cfg_data
);

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;          // coordinate difference
    localparam int PRW   = 2 * DW;          // product of differences
    localparam int SW    = 2 * DW + 2;      // dot product of differences
    localparam int XW    = 2 * DW + 1;      // cross product component
    localparam int RW    = sti_pkg::RADIUS_WIDTH;
    localparam int R2W   = 2 * RW;          // squared radius
    localparam int R2SW  = R2W + 1;         // squared radius as signed
    localparam int SQW   = 2 * XW + 2;      // dot product of cross products
    localparam int PDW   = XW + DW + 2;     // plane distance
    localparam int RLW   = R2SW + SW;
    localparam int RNW   = R2SW + SQW;
    localparam int PD2W  = 2 * PDW;
    localparam int ML    = sti_pkg::MUL_LATENCY;
    localparam int DEPTH = 5 + 2 * ML;
    localparam int SETW  = $clog2(sti_pkg::SETTLE_CYCLES + 1);

    // ------------------------------------------------------------------
    // Configuration registers and setup settle counter
    // ------------------------------------------------------------------
    logic [3*CW-1:0]        vtx_reg [3];
    logic [SETW-1:0]        settle_reg;
    logic signed [CW-1:0]   vc [3][3];
    logic                   busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < 3; v++)
            begin
                vtx_reg[v] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sti_pkg::REG_VERTEX_A: vtx_reg[0] <= cfg_data;
                sti_pkg::REG_VERTEX_B: vtx_reg[1] <= cfg_data;
                sti_pkg::REG_VERTEX_C: vtx_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Restart the settle count on every write, count down otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETW'(sti_pkg::SETTLE_CYCLES);
        end
        else if (cfg_valid && cfg_ready)
        begin
            settle_reg <= SETW'(sti_pkg::SETTLE_CYCLES);
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - SETW'(1);
        end
    end

    assign busy = (settle_reg != '0) || cfg_valid;

    // Unpack coordinates: x low, then y, then z
    always_comb
    begin
        for (int v = 0; v < 3; v++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                vc[v][c] = vtx_reg[v][c*CW +: CW];
            end
        end
    end

    // ------------------------------------------------------------------
    // Triangle setup pipeline (free running, stable between writes)
    // ------------------------------------------------------------------
    logic signed [DW-1:0]   de_reg [3][3];
    logic signed [PRW-1:0]  dlp_reg [3][3];
    logic signed [PRW-1:0]  dn1_reg [3];
    logic signed [PRW-1:0]  dn2_reg [3];
    logic signed [SW-1:0]   len2_reg [3];
    logic signed [XW-1:0]   n_reg [3];
    logic                   degen_reg;
    logic signed [2*XW-1:0] nnp [3];
    logic signed [SQW-1:0]  nn_reg;

    // Edge vectors e_i = v_(i+1) - v_i
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                de_reg[i][c] <= DW'(vc[(i+1)%3][c]) - DW'(vc[i][c]);
            end
        end
    end

    // Squared edge terms and normal n = e2 x e0 products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                dlp_reg[i][c] <= de_reg[i][c] * de_reg[i][c];
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            dn1_reg[c] <= de_reg[2][(c+1)%3] * de_reg[0][(c+2)%3];
            dn2_reg[c] <= de_reg[2][(c+2)%3] * de_reg[0][(c+1)%3];
        end
    end

    // Edge lengths squared and normal components
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            len2_reg[i] <= SW'(dlp_reg[i][0]) + SW'(dlp_reg[i][1]) + SW'(dlp_reg[i][2]);
        end
        for (int c = 0; c < 3; c++)
        begin
            n_reg[c] <= XW'(dn1_reg[c]) - XW'(dn2_reg[c]);
        end
    end

    // Flag a collinear triangle (zero normal) and form |n|^2
    always_ff @(posedge clk)
    begin
        degen_reg <= (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
        nn_reg    <= SQW'(nnp[0]) + SQW'(nnp[1]) + SQW'(nnp[2]);
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_nn
        sti_mul #(.AW(XW), .BW(XW)) u_nn_mul (
            .clk (clk),
            .en  (1'b1),
            .a   (n_reg[c]),
            .b   (n_reg[c]),
            .p   (nnp[c])
        );
    end

    // ------------------------------------------------------------------
    // Sphere pipeline control
    // ------------------------------------------------------------------
    logic               vld_reg [DEPTH];
    logic               adv;
    logic               acc;

    assign adv      = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !adv || busy;
    assign acc      = in_valid && !in_stall;

    // Advance valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= acc;
            for (int k = 1; k < DEPTH; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: center relative to each vertex
    // ------------------------------------------------------------------
    logic signed [CW-1:0]   pc [3];
    logic signed [DW-1:0]   q_reg [3][3];
    logic [RW-1:0]          r_reg;

    assign pc[0] = center_x;
    assign pc[1] = center_y;
    assign pc[2] = center_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    q_reg[i][c] <= DW'(pc[c]) - DW'(vc[i][c]);
                end
            end
            r_reg <= sphere_radius;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: narrow products
    // ------------------------------------------------------------------
    logic signed [PRW-1:0]  qqp_reg [3][3];
    logic signed [PRW-1:0]  qep_reg [3][3];
    logic signed [PRW-1:0]  kp1_reg [3][3];
    logic signed [PRW-1:0]  kp2_reg [3][3];
    logic signed [DW-1:0]   q0b_reg [3];
    logic [R2W-1:0]         r2b_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    qqp_reg[i][c] <= q_reg[i][c] * q_reg[i][c];
                    qep_reg[i][c] <= q_reg[i][c] * de_reg[i][c];
                    kp1_reg[i][c] <= q_reg[i][(c+1)%3] * de_reg[i][(c+2)%3];
                    kp2_reg[i][c] <= q_reg[i][(c+2)%3] * de_reg[i][(c+1)%3];
                end
            end
            for (int c = 0; c < 3; c++)
            begin
                q0b_reg[c] <= q_reg[0][c];
            end
            r2b_reg <= r_reg * r_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: distances to vertices, edge projections, q x e
    // ------------------------------------------------------------------
    logic signed [SW-1:0]   qq_reg [3];
    logic signed [SW-1:0]   s_reg [3];
    logic signed [XW-1:0]   k_reg [3][3];
    logic signed [DW-1:0]   q0c_reg [3];
    logic [R2W-1:0]         r2c_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                qq_reg[i] <= SW'(qqp_reg[i][0]) + SW'(qqp_reg[i][1]) + SW'(qqp_reg[i][2]);
                s_reg[i]  <= SW'(qep_reg[i][0]) + SW'(qep_reg[i][1]) + SW'(qep_reg[i][2]);
                for (int c = 0; c < 3; c++)
                begin
                    k_reg[i][c] <= XW'(kp1_reg[i][c]) - XW'(kp2_reg[i][c]);
                end
            end
            for (int c = 0; c < 3; c++)
            begin
                q0c_reg[c] <= q0b_reg[c];
            end
            r2c_reg <= r2b_reg;
        end
    end

    // Vertex-in-sphere and projection-on-segment flags
    logic [3:0]             fc;     // {vertex hit, segment range per edge}
    logic [3:0]             f1_reg [ML];
    logic [R2W-1:0]         r2d_reg [ML];
    logic [R2SW-1:0]        r2c_s;

    assign r2c_s = {1'b0, r2c_reg};

    always_comb
    begin
        fc[3] = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (qq_reg[i] <= $signed(r2c_s))
            begin
                fc[3] = 1'b1;
            end
            fc[i] = (s_reg[i] >= 0) && (s_reg[i] <= len2_reg[i]);
        end
    end

    // Delay flags and r^2 across the wide multipliers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg[0]  <= fc;
            r2d_reg[0] <= r2c_reg;
            for (int k = 1; k < ML; k++)
            begin
                f1_reg[k]  <= f1_reg[k-1];
                r2d_reg[k] <= r2d_reg[k-1];
            end
        end
    end

    // Wide products: |q x e|^2 terms, n.(q x e) terms, n.q0, r^2 |e|^2
    logic signed [2*XW-1:0] kkp [3][3];
    logic signed [2*XW-1:0] nkp [3][3];
    logic signed [XW+DW-1:0] pdp [3];
    logic signed [RLW-1:0]  rlp [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_edge
        for (genvar c = 0; c < 3; c++)
        begin : g_comp
            sti_mul #(.AW(XW), .BW(XW)) u_kk_mul (
                .clk (clk),
                .en  (adv),
                .a   (k_reg[i][c]),
                .b   (k_reg[i][c]),
                .p   (kkp[i][c])
            );
            sti_mul #(.AW(XW), .BW(XW)) u_nk_mul (
                .clk (clk),
                .en  (adv),
                .a   (n_reg[c]),
                .b   (k_reg[i][c]),
                .p   (nkp[i][c])
            );
        end
        sti_mul #(.AW(R2SW), .BW(SW)) u_rl_mul (
            .clk (clk),
            .en  (adv),
            .a   (r2c_s),
            .b   (len2_reg[i]),
            .p   (rlp[i])
        );
        sti_mul #(.AW(XW), .BW(DW)) u_pd_mul (
            .clk (clk),
            .en  (adv),
            .a   (n_reg[i]),
            .b   (q0c_reg[i]),
            .p   (pdp[i])
        );
    end

    // ------------------------------------------------------------------
    // Stage H: sum the wide products
    // ------------------------------------------------------------------
    logic signed [SQW-1:0]  kk_reg [3];
    logic signed [SQW-1:0]  nk_reg [3];
    logic signed [RLW-1:0]  rl_reg [3];
    logic signed [PDW-1:0]  pd_reg;
    logic [3:0]             fh_reg;
    logic [R2W-1:0]         r2h_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                kk_reg[i] <= SQW'(kkp[i][0]) + SQW'(kkp[i][1]) + SQW'(kkp[i][2]);
                nk_reg[i] <= SQW'(nkp[i][0]) + SQW'(nkp[i][1]) + SQW'(nkp[i][2]);
                rl_reg[i] <= rlp[i];
            end
            pd_reg  <= PDW'(pdp[0]) + PDW'(pdp[1]) + PDW'(pdp[2]);
            fh_reg  <= f1_reg[ML-1];
            r2h_reg <= r2d_reg[ML-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage I: edge and inside tests, then delay to meet the face test
    // ------------------------------------------------------------------
    logic [2:0]             fi;     // {vertex hit, edge hit, center inside}
    logic [2:0]             f2_reg [ML];
    logic [R2SW-1:0]        r2h_s;

    always_comb
    begin
        fi[2] = fh_reg[3];
        fi[1] = 1'b0;
        fi[0] = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (fh_reg[i] && (kk_reg[i] <= rl_reg[i]))
            begin
                fi[1] = 1'b1;
            end
            if (nk_reg[i] > 0)
            begin
                fi[0] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f2_reg[0] <= fi;
            for (int k = 1; k < ML; k++)
            begin
                f2_reg[k] <= f2_reg[k-1];
            end
        end
    end

    assign r2h_s = {1'b0, r2h_reg};

    // Face test products: pd^2 against r^2 |n|^2
    logic signed [PD2W-1:0] pd2;
    logic signed [RNW-1:0]  rn;

    sti_mul #(.AW(PDW), .BW(PDW)) u_pd2_mul (
        .clk (clk),
        .en  (adv),
        .a   (pd_reg),
        .b   (pd_reg),
        .p   (pd2)
    );

    sti_mul #(.AW(R2SW), .BW(SQW)) u_rn_mul (
        .clk (clk),
        .en  (adv),
        .a   (r2h_s),
        .b   (nn_reg),
        .p   (rn)
    );

    // ------------------------------------------------------------------
    // Stage M: combine into the result register
    // ------------------------------------------------------------------
    logic   hit_reg;
    logic   hit_next;

    always_comb
    begin
        hit_next = !degen_reg
                   && (f2_reg[ML-1][2] || f2_reg[ML-1][1]
                       || (f2_reg[ML-1][0] && (pd2 <= rn)));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit       = hit_reg;
    assign out_valid = vld_reg[DEPTH-1];

endmodule

`default_nettype wire
